/* rtl/ookfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ookfs_pkg: shared types and constants of the OOK frame sender
// Command codes, queue entry layout, register indexes and reset values.
// ----------------------------------------------------------------------------
package ookfs_pkg;

  // Item kinds as they arrive on the input tuser field.
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Classified operation handed from the front end to the engine.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] byte_value;
  } cmd_t;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_LONG         = 3'd0;
  localparam logic [2:0] REG_SHORT        = 3'd1;
  localparam logic [2:0] REG_START_HIGH   = 3'd2;
  localparam logic [2:0] REG_START_LOW    = 3'd3;
  localparam logic [2:0] REG_FRAME_BYTES  = 3'd4;
  localparam logic [2:0] REG_REPEAT_COUNT = 3'd5;

  // Positions in the array of timing registers.
  localparam logic [1:0] T_LONG       = 2'd0;
  localparam logic [1:0] T_SHORT      = 2'd1;
  localparam logic [1:0] T_START_HIGH = 2'd2;
  localparam logic [1:0] T_START_LOW  = 2'd3;

  // Reset values of the registers.
  localparam int unsigned RST_LONG         = 1600;
  localparam int unsigned RST_SHORT        = 400;
  localparam int unsigned RST_START_HIGH   = 3000;
  localparam int unsigned RST_START_LOW    = 6000;
  localparam logic [3:0]  RST_FRAME_BYTES  = 4'd7;
  localparam logic [3:0]  RST_REPEAT_COUNT = 4'd5;

endpackage
`default_nettype wire

/* rtl/pulse_width_ook_frame_sender.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_width_ook_frame_sender: pulse-width OOK frame sender
// Turns loaded frame bytes into the on/off line pattern of a 433 MHz
// transmitter, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries the item kind in in_tuser (load byte, start,
//   one microsecond tick) and the frame byte in in_tdata. Every input
//   transaction yields exactly one result transaction: out_tdata bit 0 is the
//   line level, bit 1 is busy, and out_tlast marks the tick that ends the
//   last repeat of the frame. Timing and frame registers sit on the APB port
//   and must be written while the block is idle; the block does not enforce it.
//   An accepted input passes through the two-entry command queue and then
//   the engine's output register before its result leaves.
//   Throughput is one transaction per cycle while results are taken; the
//   engine retires one command per cycle unless its result is stalled, and the
//   next frame byte is prefetched from the store ahead of the byte boundary.
//   Reset clears the frame store, the queue and the engine: the line idles low.
//   When the receiver stalls, the output register holds its result, the
//   queue fills within two transactions and then in_tready drops.
// ----------------------------------------------------------------------------
module pulse_width_ook_frame_sender
  import ookfs_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 8,
  parameter int TIME_BITS       = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] byte_value
  input  logic [1:0]  in_tuser,    // [1:0] kind
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] line_level, [1] busy_res, [7:2] zero
  output logic        out_tlast,   // frame_done
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic                 q_valid;
  logic                 q_pop;
  cmd_t                 q_cmd;
  logic [TIME_BITS-1:0] time_cfg [4];
  logic [3:0]           frame_bytes;
  logic [3:0]           repeat_count;

  // Register file.
  ookfs_cfg #(
    .TIME_BITS (TIME_BITS)
  ) u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .time_cfg     (time_cfg),
    .frame_bytes  (frame_bytes),
    .repeat_count (repeat_count)
  );

  // Front end: classify and queue.
  ookfs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  // Back end: transmit engine.
  ookfs_engine #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .TIME_BITS       (TIME_BITS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_cmd        (q_cmd),
    .q_pop        (q_pop),
    .time_cfg     (time_cfg),
    .frame_bytes  (frame_bytes),
    .repeat_count (repeat_count),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule
`default_nettype wire

/* rtl/ookfs_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ookfs_cfg: configuration register file
// APB-style slave holding the timing, frame length and repeat registers.
// ----------------------------------------------------------------------------
module ookfs_cfg
  import ookfs_pkg::*;
#(
  parameter int TIME_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [4:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready,
  output logic [TIME_BITS-1:0] time_cfg [4],
  output logic [3:0]           frame_bytes,
  output logic [3:0]           repeat_count
);

  logic [TIME_BITS-1:0] time_r [4];
  logic [3:0]           frame_bytes_r;
  logic [3:0]           repeat_count_r;
  logic [2:0]           reg_idx;
  logic                 wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r[T_LONG]       <= TIME_BITS'(RST_LONG);
      time_r[T_SHORT]      <= TIME_BITS'(RST_SHORT);
      time_r[T_START_HIGH] <= TIME_BITS'(RST_START_HIGH);
      time_r[T_START_LOW]  <= TIME_BITS'(RST_START_LOW);
      frame_bytes_r        <= RST_FRAME_BYTES;
      repeat_count_r       <= RST_REPEAT_COUNT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LONG:         time_r[T_LONG]       <= cfg_pwdata[TIME_BITS-1:0];
        REG_SHORT:        time_r[T_SHORT]      <= cfg_pwdata[TIME_BITS-1:0];
        REG_START_HIGH:   time_r[T_START_HIGH] <= cfg_pwdata[TIME_BITS-1:0];
        REG_START_LOW:    time_r[T_START_LOW]  <= cfg_pwdata[TIME_BITS-1:0];
        REG_FRAME_BYTES:  frame_bytes_r        <= cfg_pwdata[3:0];
        REG_REPEAT_COUNT: repeat_count_r       <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read data follows the address.
  always_comb begin
    unique case (reg_idx)
      REG_LONG:         cfg_prdata = 32'(time_r[T_LONG]);
      REG_SHORT:        cfg_prdata = 32'(time_r[T_SHORT]);
      REG_START_HIGH:   cfg_prdata = 32'(time_r[T_START_HIGH]);
      REG_START_LOW:    cfg_prdata = 32'(time_r[T_START_LOW]);
      REG_FRAME_BYTES:  cfg_prdata = 32'(frame_bytes_r);
      REG_REPEAT_COUNT: cfg_prdata = 32'(repeat_count_r);
      default:          cfg_prdata = 32'd0;
    endcase
  end

  assign time_cfg     = time_r;
  assign frame_bytes  = frame_bytes_r;
  assign repeat_count = repeat_count_r;

endmodule
`default_nettype wire

/* rtl/ookfs_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ookfs_front: input front end
// Accepts input transactions, classifies the kind into an operation and
// holds the commands in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module ookfs_front
  import ookfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] byte_value
  input  logic [1:0] in_tuser,   // [1:0] kind
  output logic       q_valid,
  output cmd_t       q_cmd,
  input  logic       q_pop
);

  cmd_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       push;
  cmd_t       cmd_in;

  // Classify the incoming kind.
  always_comb begin
    cmd_in.byte_value = in_tdata;
    unique case (in_tuser)
      KIND_LOAD:  cmd_in.op = OP_LOAD;
      KIND_START: cmd_in.op = OP_START;
      KIND_TICK:  cmd_in.op = OP_TICK;
      default:    cmd_in.op = OP_NOP;
    endcase
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid & in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_cmd     = slot_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/ookfs_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ookfs_engine: transmit engine
// Executes one queued command per cycle while the output register is not
// stalled: stores frame bytes, starts a transmission and times the line
// segments. Results leave through an output register.
// ----------------------------------------------------------------------------
module ookfs_engine
  import ookfs_pkg::*;
#(
  parameter int MAX_FRAME_BYTES = 8,
  parameter int TIME_BITS       = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  cmd_t                 q_cmd,
  output logic                 q_pop,
  input  logic [TIME_BITS-1:0] time_cfg [4],
  input  logic [3:0]           frame_bytes,
  input  logic [3:0]           repeat_count,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [0] line_level, [1] busy_res
  output logic                 out_tlast   // frame_done
);

  localparam int SLOT_W = (MAX_FRAME_BYTES > 1) ? $clog2(MAX_FRAME_BYTES) : 1;
  localparam int LOAD_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int BW     = (LOAD_W > 4) ? LOAD_W : 4;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_START_HI = 5'b00010,
    PH_START_LO = 5'b00100,
    PH_BIT_HI   = 5'b01000,
    PH_BIT_LO   = 5'b10000
  } phase_t;

  function automatic logic [TIME_BITS-1:0] at_least_one(input logic [TIME_BITS-1:0] t);
    return (t == '0) ? TIME_BITS'(1) : t;
  endfunction

  // Frame store with one valid bit per entry so reset reads as zero.
  logic [7:0]                 store_mem [MAX_FRAME_BYTES];
  logic [MAX_FRAME_BYTES-1:0] store_v_r;
  logic [7:0]                 rd_data_r;
  logic [SLOT_W-1:0]          rd_addr;
  logic                       mem_we;

  phase_t               phase_r,      phase_nxt;
  logic [TIME_BITS-1:0] time_left_r,  time_left_nxt;
  logic [SLOT_W-1:0]    byte_slot_r,  byte_slot_nxt;
  logic [2:0]           bit_slot_r,   bit_slot_nxt;
  logic [3:0]           repeats_r,    repeats_nxt;
  logic                 line_r,       line_nxt;
  logic [LOAD_W-1:0]    load_slot_r,  load_slot_nxt;
  logic [7:0]           cur_byte_r,   cur_byte_nxt;

  logic       out_valid_r;
  logic       level_r;
  logic       busy_r;
  logic       done_r;
  logic       level;
  logic       busy;
  logic       done;
  logic [3:0] rep_dec;
  logic [BW-1:0] bpf;
  logic [BW-1:0] fb_ext;
  logic          last_byte;

  // Bytes per frame, clamped to one and to the store depth.
  always_comb begin
    fb_ext = BW'(frame_bytes);
    if (frame_bytes == 4'd0) begin
      bpf = BW'(1);
    end else if (fb_ext > BW'(MAX_FRAME_BYTES)) begin
      bpf = BW'(MAX_FRAME_BYTES);
    end else begin
      bpf = fb_ext;
    end
  end

  assign last_byte = (BW'(byte_slot_r) + BW'(1)) >= bpf;

  // Prefetch address: the byte that the next byte boundary will need.
  always_comb begin
    if ((phase_r == PH_BIT_HI || phase_r == PH_BIT_LO) && !last_byte) begin
      rd_addr = byte_slot_r + SLOT_W'(1);
    end else begin
      rd_addr = '0;
    end
  end

  assign q_pop = q_valid & (~out_valid_r | out_tready);

  // Command execution and segment timing.
  always_comb begin
    phase_nxt     = phase_r;
    time_left_nxt = time_left_r;
    byte_slot_nxt = byte_slot_r;
    bit_slot_nxt  = bit_slot_r;
    repeats_nxt   = repeats_r;
    line_nxt      = line_r;
    load_slot_nxt = load_slot_r;
    cur_byte_nxt  = cur_byte_r;
    mem_we        = 1'b0;
    rep_dec       = repeats_r - 4'(repeats_r != 4'd0);
    level         = line_r;
    busy          = (phase_r != PH_IDLE);
    done          = 1'b0;

    if (q_pop) begin
      case (q_cmd.op)
        OP_LOAD: begin
          if (!busy && load_slot_r < LOAD_W'(MAX_FRAME_BYTES)) begin
            mem_we        = 1'b1;
            load_slot_nxt = load_slot_r + LOAD_W'(1);
          end
        end
        OP_START: begin
          if (!busy) begin
            load_slot_nxt = '0;
            repeats_nxt   = (repeat_count == 4'd0) ? 4'd1 : repeat_count;
            phase_nxt     = PH_START_HI;
            line_nxt      = 1'b1;
            time_left_nxt = at_least_one(time_cfg[T_START_HIGH]);
            byte_slot_nxt = '0;
            bit_slot_nxt  = 3'd0;
            level         = 1'b1;
            busy          = 1'b1;
          end
        end
        OP_TICK: begin
          if (busy) begin
            if (time_left_r > TIME_BITS'(1)) begin
              time_left_nxt = time_left_r - TIME_BITS'(1);
            end else begin
              unique case (phase_r)
                PH_START_HI: begin
                  phase_nxt     = PH_START_LO;
                  line_nxt      = 1'b0;
                  time_left_nxt = at_least_one(time_cfg[T_START_LOW]);
                end
                PH_START_LO: begin
                  byte_slot_nxt = '0;
                  bit_slot_nxt  = 3'd0;
                  cur_byte_nxt  = rd_data_r;
                  phase_nxt     = PH_BIT_HI;
                  line_nxt      = 1'b1;
                  time_left_nxt = at_least_one(rd_data_r[7] ? time_cfg[T_LONG]
                                                            : time_cfg[T_SHORT]);
                end
                PH_BIT_HI: begin
                  phase_nxt     = PH_BIT_LO;
                  line_nxt      = 1'b0;
                  time_left_nxt = at_least_one(cur_byte_r[3'd7 - bit_slot_r]
                                               ? time_cfg[T_SHORT] : time_cfg[T_LONG]);
                end
                PH_BIT_LO: begin
                  if (bit_slot_r == 3'd7) begin
                    bit_slot_nxt = 3'd0;
                    if (last_byte) begin
                      // End of frame: repeat or finish.
                      byte_slot_nxt = '0;
                      repeats_nxt   = rep_dec;
                      if (rep_dec == 4'd0) begin
                        phase_nxt     = PH_IDLE;
                        line_nxt      = 1'b0;
                        time_left_nxt = '0;
                        done          = 1'b1;
                      end else begin
                        phase_nxt     = PH_START_HI;
                        line_nxt      = 1'b1;
                        time_left_nxt = at_least_one(time_cfg[T_START_HIGH]);
                      end
                    end else begin
                      // Next byte comes from the prefetch register.
                      byte_slot_nxt = byte_slot_r + SLOT_W'(1);
                      cur_byte_nxt  = rd_data_r;
                      phase_nxt     = PH_BIT_HI;
                      line_nxt      = 1'b1;
                      time_left_nxt = at_least_one(rd_data_r[7] ? time_cfg[T_LONG]
                                                                : time_cfg[T_SHORT]);
                    end
                  end else begin
                    bit_slot_nxt  = bit_slot_r + 3'd1;
                    phase_nxt     = PH_BIT_HI;
                    line_nxt      = 1'b1;
                    time_left_nxt = at_least_one(cur_byte_r[3'd6 - bit_slot_r]
                                                 ? time_cfg[T_LONG] : time_cfg[T_SHORT]);
                  end
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Frame store write port and registered prefetch read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[load_slot_r[SLOT_W-1:0]] <= q_cmd.byte_value;
    end
    rd_data_r <= store_v_r[rd_addr] ? store_mem[rd_addr] : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_v_r <= '0;
    end else if (mem_we) begin
      store_v_r[load_slot_r[SLOT_W-1:0]] <= 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      time_left_r <= '0;
      byte_slot_r <= '0;
      bit_slot_r  <= 3'd0;
      repeats_r   <= 4'd0;
      line_r      <= 1'b0;
      load_slot_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      time_left_r <= time_left_nxt;
      byte_slot_r <= byte_slot_nxt;
      bit_slot_r  <= bit_slot_nxt;
      repeats_r   <= repeats_nxt;
      line_r      <= line_nxt;
      load_slot_r <= load_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_byte_r <= cur_byte_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      level_r <= level;
      busy_r  <= busy;
      done_r  <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, busy_r, level_r};
  assign out_tlast  = done_r;

endmodule
`default_nettype wire

/* rtl/ookfs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ookfs_checker: port-level checks of the OOK frame sender
// Watches the top-level ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module ookfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       cfg_pready
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // The final tick of a transmission is busy and drives the line low.
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[1] && !out_tdata[0])
    else $error("frame_done without busy or with line high");

  // The line is never high while the sender is idle.
  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> !out_tdata[0] && !out_tlast)
    else $error("line high or done while idle");

  // No result comes out right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

  // The configuration port never inserts wait states.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port not ready");

endmodule

bind pulse_width_ook_frame_sender ookfs_checker u_ookfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the pulse-width OOK frame sender
// Loads frame bytes, programs the timing and frame registers over APB and
// sends frames tick by tick. An in-house line model predicts the level, busy
// flag and end-of-transmission flag of every result transaction; both stream
// sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import ookfs_pkg::*;

  localparam int         FRAME_SLOTS    = 8;
  localparam int         IDLE_PERCENT   = 28;
  localparam int         WATCHDOG_LIMIT = 1000;
  localparam int         RANDOM_ITEMS   = 80;
  // Longest transmission, in ticks, that a random setting may ask for.
  localparam int         SEND_TICKS_MAX = 80;
  localparam logic [1:0] KIND_UNUSED    = 2'd3;
  // Register indexes past the last one; writes there must be ignored.
  localparam logic [2:0] REG_SPARE_A    = 3'd6;
  localparam logic [2:0] REG_SPARE_B    = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
  } line_cmd_t;

  typedef struct packed {
    logic line_level;
    logic busy;
    logic frame_done;
  } line_sample_t;

  typedef enum logic [2:0] {
    SEG_IDLE,
    SEG_START_HI,
    SEG_START_LO,
    SEG_BIT_HI,
    SEG_BIT_LO
  } seg_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;    // [7:0] byte_value
  logic [1:0]  in_tuser = '0;    // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;        // [0] line_level, [1] busy_res, [7:2] zero
  logic        out_tlast;        // frame_done
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // No random idling on either side while this is set.
  logic steady = 1'b0;

  line_cmd_t    pending_cmds[$];
  line_sample_t expected_levels[$];
  int           mismatch_count = 0;
  int           quiet_cycles = 0;
  int           random_items = 0;

  pulse_width_ook_frame_sender u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Line model: register copies and sender state.
  // --------------------------------------------------------------------------
  logic [13:0] cfg_long;
  logic [13:0] cfg_short;
  logic [13:0] cfg_start_high;
  logic [13:0] cfg_start_low;
  logic [3:0]  cfg_frame_bytes;
  logic [3:0]  cfg_repeats;

  logic [7:0]  frame_mem [FRAME_SLOTS];
  int          load_pos;
  seg_t        seg;
  logic [13:0] ticks_left;
  int          byte_pos;
  int          bit_pos;
  int          reps_left;
  logic        line_now;

  function automatic void reset_model();
    cfg_long        = 14'(RST_LONG);
    cfg_short       = 14'(RST_SHORT);
    cfg_start_high  = 14'(RST_START_HIGH);
    cfg_start_low   = 14'(RST_START_LOW);
    cfg_frame_bytes = RST_FRAME_BYTES;
    cfg_repeats     = RST_REPEAT_COUNT;
    foreach (frame_mem[k]) frame_mem[k] = '0;
    load_pos   = 0;
    seg        = SEG_IDLE;
    ticks_left = '0;
    byte_pos   = 0;
    bit_pos    = 0;
    reps_left  = 0;
    line_now   = 1'b0;
  endfunction

  // A programmed time of zero still lasts one tick.
  function automatic logic [13:0] min_one(input logic [13:0] t);
    return (t == '0) ? 14'd1 : t;
  endfunction

  // Bytes per frame: zero counts as one, anything past the store saturates.
  function automatic int bytes_in_frame();
    int n;
    n = (cfg_frame_bytes == '0) ? 1 : int'(cfg_frame_bytes);
    return (n > FRAME_SLOTS) ? FRAME_SLOTS : n;
  endfunction

  function automatic logic bit_now();
    if (byte_pos >= FRAME_SLOTS) return 1'b0;
    return frame_mem[byte_pos][7 - bit_pos];
  endfunction

  function automatic void begin_frame_seg();
    seg        = SEG_START_HI;
    line_now   = 1'b1;
    ticks_left = min_one(cfg_start_high);
    byte_pos   = 0;
    bit_pos    = 0;
  endfunction

  function automatic void begin_bit_seg();
    seg        = SEG_BIT_HI;
    line_now   = 1'b1;
    ticks_left = min_one(bit_now() ? cfg_long : cfg_short);
  endfunction

  // Moves to the next line segment; returns 1 when the last repeat ends.
  function automatic logic next_segment();
    case (seg)
      SEG_START_HI: begin
        seg        = SEG_START_LO;
        line_now   = 1'b0;
        ticks_left = min_one(cfg_start_low);
      end
      SEG_START_LO: begin
        byte_pos = 0;
        bit_pos  = 0;
        begin_bit_seg();
      end
      SEG_BIT_HI: begin
        seg        = SEG_BIT_LO;
        line_now   = 1'b0;
        ticks_left = min_one(bit_now() ? cfg_short : cfg_long);
      end
      default: begin
        bit_pos++;
        if (bit_pos >= 8) begin
          bit_pos = 0;
          byte_pos++;
          if (byte_pos >= bytes_in_frame()) begin
            byte_pos = 0;
            if (reps_left > 0) reps_left--;
            if (reps_left == 0) begin
              seg        = SEG_IDLE;
              line_now   = 1'b0;
              ticks_left = '0;
              return 1'b1;
            end
            begin_frame_seg();
            return 1'b0;
          end
        end
        begin_bit_seg();
      end
    endcase
    return 1'b0;
  endfunction

  // Applies one command to the line model and returns the result it causes.
  function automatic line_sample_t predict_line(input logic [1:0] kind,
                                                input logic [7:0] data);
    logic level;
    logic busy;
    logic done;
    level = line_now;
    busy  = (seg != SEG_IDLE);
    done  = 1'b0;
    case (kind)
      KIND_LOAD: begin
        if (!busy && load_pos < FRAME_SLOTS) begin
          frame_mem[load_pos] = data;
          load_pos++;
        end
      end
      KIND_START: begin
        if (!busy) begin
          load_pos  = 0;
          reps_left = (cfg_repeats == '0) ? 1 : int'(cfg_repeats);
          begin_frame_seg();
          level = line_now;
          busy  = 1'b1;
        end
      end
      KIND_TICK: begin
        if (busy) begin
          if (ticks_left <= 14'd1) done = next_segment();
          else ticks_left--;
        end
      end
      default: ;
    endcase
    return '{line_level: level, busy: busy, frame_done: done};
  endfunction

  // Ticks from start to the end of the last repeat. Every bit lasts
  // long + short whatever its value, so the frame contents do not matter.
  function automatic int frame_run_ticks();
    int reps;
    int per_frame;
    reps      = (cfg_repeats == '0) ? 1 : int'(cfg_repeats);
    per_frame = int'(min_one(cfg_start_high)) + int'(min_one(cfg_start_low))
              + bytes_in_frame() * 8 * (int'(min_one(cfg_long)) + int'(min_one(cfg_short)));
    return reps * per_frame;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: presents queued commands, idling at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : cmd_driver
    line_cmd_t cmd;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_cmds.size() > 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
        cmd = pending_cmds.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= cmd.kind;
        in_tdata  <= cmd.byte_value;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every input transaction, checks every result
  // transaction in order, and stops a run that has hung.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : line_monitor
    line_sample_t want;
    line_sample_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) expected_levels.push_back(predict_line(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        got = '{line_level: out_tdata[0], busy: out_tdata[1], frame_done: out_tlast};
        if (expected_levels.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual level=%0b busy=%0b done=%0b",
                   $time, got.line_level, got.busy, got.frame_done);
        end else begin
          want = expected_levels.pop_front();
          if (got !== want) begin
            mismatch_count++;
            $display({"%0t: result mismatch, expected level=%0b busy=%0b done=%0b,",
                      " actual level=%0b busy=%0b done=%0b"},
                     $time, want.line_level, want.busy, want.frame_done,
                     got.line_level, got.busy, got.frame_done);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** pulse_width_ook_frame_sender: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_LONG:         cfg_long        = val[13:0];
      REG_SHORT:        cfg_short       = val[13:0];
      REG_START_HIGH:   cfg_start_high  = val[13:0];
      REG_START_LOW:    cfg_start_low   = val[13:0];
      REG_FRAME_BYTES:  cfg_frame_bytes = val[3:0];
      REG_REPEAT_COUNT: cfg_repeats     = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [31:0] long_t, input logic [31:0] short_t,
                            input logic [31:0] high_t, input logic [31:0] low_t,
                            input logic [31:0] nbytes, input logic [31:0] reps);
    cfg_write(REG_LONG, long_t);
    cfg_write(REG_SHORT, short_t);
    cfg_write(REG_START_HIGH, high_t);
    cfg_write(REG_START_LOW, low_t);
    cfg_write(REG_FRAME_BYTES, nbytes);
    cfg_write(REG_REPEAT_COUNT, reps);
  endtask

  // Random short time, now and then zero, sometimes with junk above the field.
  function automatic logic [31:0] pick_time();
    logic [31:0] t;
    t = ($urandom_range(99) < 8) ? 32'd0 : 32'($urandom_range(1, 3));
    if ($urandom_range(3) == 0) t |= $urandom & 32'hFFFF_C000;
    return t;
  endfunction

  function automatic logic [31:0] pick_count(input int hi);
    logic [31:0] c;
    int r;
    r = $urandom_range(99);
    if (r < 10) c = 32'd0;
    else if (r < 18) c = 32'($urandom_range(hi, 15));
    else c = 32'($urandom_range(1, 2));
    if ($urandom_range(3) == 0) c |= $urandom & 32'hFFFF_FFF0;
    return c;
  endfunction

  task automatic queue_item(input logic [1:0] kind, input logic [7:0] data);
    pending_cmds.push_back('{kind: kind, byte_value: data});
    random_items++;
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_item(KIND_TICK, 8'($urandom));
  endtask

  // One transmission: loads, a start, then exactly the ticks it lasts, with ignored loads,
  // starts and unused kinds sprinkled in while it is busy, then up to three idle ticks.
  task automatic queue_send(input int n_loads);
    int total;
    logic [1:0] noise_kind;
    repeat (n_loads) queue_item(KIND_LOAD, 8'($urandom));
    queue_item(KIND_START, 8'($urandom));
    total = frame_run_ticks();
    for (int t = 0; t < total; t++) begin
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(2))
          0:       noise_kind = KIND_LOAD;
          1:       noise_kind = KIND_START;
          default: noise_kind = KIND_UNUSED;
        endcase
        pending_cmds.push_back('{kind: noise_kind, byte_value: 8'($urandom)});
      end
      queue_item(KIND_TICK, 8'($urandom));
    end
    queue_ticks($urandom_range(0, 3));
    if ($urandom_range(1) == 0) queue_item(KIND_UNUSED, 8'($urandom));
  endtask

  // Waits until every command has gone through and every result is checked,
  // then lets the pipeline settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_levels.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] corner_bytes [10];
    corner_bytes = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h80,
                     8'h01, 8'h7F, 8'hFE, 8'h3C, 8'hC3};
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Idle behavior at reset, then more loads than the store holds.
    queue_item(KIND_TICK, 8'hFF);
    queue_item(KIND_UNUSED, 8'h00);
    foreach (corner_bytes[k]) queue_item(KIND_LOAD, corner_bytes[k]);
    wait_drained();

    // Zero times, zero frame length and zero repeats all count as one.
    set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    cfg_write(REG_SPARE_A, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_B, 32'h0000_0000);
    queue_item(KIND_START, 8'h00);
    queue_item(KIND_START, 8'hFF);
    queue_item(KIND_LOAD, 8'h3C);
    queue_item(KIND_UNUSED, 8'hFF);
    queue_ticks(frame_run_ticks() + 2);
    wait_drained();

    // Lopsided long and short halves, then a full frame with saturated length.
    steady <= 1'b1;
    set_config(32'd6, 32'd1, 32'd1, 32'd6, 32'd1, 32'd1);
    queue_send(1);
    wait_drained();
    set_config(32'd1, 32'd6, 32'd6, 32'd1, 32'd1, 32'd1);
    queue_send(1);
    wait_drained();
    set_config(32'd1, 32'd1, 32'd1, 32'd1, 32'd15, 32'd1);
    queue_send(FRAME_SLOTS);
    wait_drained();
    steady <= 1'b0;

    // Random settings, each followed by one or two transmissions.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      // Draw again while a transmission would run too long.
      do begin
        set_config(pick_time(), pick_time(), pick_time(), pick_time(),
                   pick_count(FRAME_SLOTS), pick_count(3));
      end while (frame_run_ticks() > SEND_TICKS_MAX);
      if ($urandom_range(3) == 0) cfg_write(REG_SPARE_A, $urandom);
      repeat ($urandom_range(1, 2)) queue_send($urandom_range(0, 10));
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("** pulse_width_ook_frame_sender: PASSED **");
    end else begin
      $display("** pulse_width_ook_frame_sender: FAILED **");
    end
    $finish;
  end

endmodule
